// ===== rtl/tgs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread grid split package
// Widths, microcode opcodes, branch conditions, step names and the control
// store shared by the channel interfaces and the sequencer.
// ----------------------------------------------------------------------------
package tgs_pkg;

   localparam int MAX_WORKERS = 1024;
   localparam int T_W         = 11;   // worker count and split fields
   localparam int DIM_W       = 32;   // problem dimensions
   localparam int BIT_W       = 4;    // bit position of the target search
   localparam int CAND_TOP    = 10;   // highest target bit that is tried
   localparam int ODD_W       = T_W + 1;
   localparam int SQ_W        = 2 * ODD_W;
   localparam int PROD_W      = SQ_W + DIM_W;
   localparam int RHS_W       = T_W + DIM_W + 2;
   localparam int CNT_W       = 4;    // divider step count
   localparam int PC_W        = 5;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_ZERO,
      OP_RHS,
      OP_SQUARE,
      OP_PROD,
      OP_ACCEPT,
      OP_BIT_DEC,
      OP_SET_FULL,
      OP_DIV_DOWN,
      OP_DIV_UP,
      OP_DIV_STEP,
      OP_TAKE,
      OP_TAKE_NEXT,
      OP_FALLBACK,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_T_ZERO,
      C_MN_ZERO,
      C_CAND_OVER,
      C_BIT_LEFT,
      C_K_ZERO,
      C_K_GE_T,
      C_DIV_BUSY,
      C_REM_ZERO,
      C_OUT_BUSY
   } cond_type;

   typedef enum logic [PC_W-1:0] {
      S_WAIT,
      S_TZERO,
      S_RHS,
      S_SQUARE,
      S_PROD,
      S_ACCEPT,
      S_NEXTBIT,
      S_KZERO,
      S_KFULL,
      S_DOWN,
      S_DIV_A,
      S_TEST_A,
      S_UP,
      S_DIV_B,
      S_TEST_B,
      S_LOOP,
      S_FALLBACK,
      S_EMIT,
      S_RESTART
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_word_type;

   // Control store: a taken branch goes to target, otherwise to the next step.
   function automatic ucode_word_type ucode_rom(input step_type pc);
      ucode_word_type w;
      case (pc)
         S_WAIT:     w = '{OP_LATCH,     C_NO_REQ,    S_WAIT};
         S_TZERO:    w = '{OP_ZERO,      C_T_ZERO,    S_EMIT};
         S_RHS:      w = '{OP_RHS,       C_MN_ZERO,   S_FALLBACK};
         S_SQUARE:   w = '{OP_SQUARE,    C_CAND_OVER, S_NEXTBIT};
         S_PROD:     w = '{OP_PROD,      C_NEVER,     S_WAIT};
         S_ACCEPT:   w = '{OP_ACCEPT,    C_NEVER,     S_WAIT};
         S_NEXTBIT:  w = '{OP_BIT_DEC,   C_BIT_LEFT,  S_SQUARE};
         S_KZERO:    w = '{OP_NOP,       C_K_ZERO,    S_FALLBACK};
         S_KFULL:    w = '{OP_SET_FULL,  C_K_GE_T,    S_EMIT};
         S_DOWN:     w = '{OP_DIV_DOWN,  C_NEVER,     S_WAIT};
         S_DIV_A:    w = '{OP_DIV_STEP,  C_DIV_BUSY,  S_DIV_A};
         S_TEST_A:   w = '{OP_TAKE,      C_REM_ZERO,  S_EMIT};
         S_UP:       w = '{OP_DIV_UP,    C_NEVER,     S_WAIT};
         S_DIV_B:    w = '{OP_DIV_STEP,  C_DIV_BUSY,  S_DIV_B};
         S_TEST_B:   w = '{OP_TAKE_NEXT, C_REM_ZERO,  S_EMIT};
         S_LOOP:     w = '{OP_NOP,       C_ALWAYS,    S_DOWN};
         S_FALLBACK: w = '{OP_FALLBACK,  C_NEVER,     S_WAIT};
         S_EMIT:     w = '{OP_EMIT,      C_OUT_BUSY,  S_EMIT};
         S_RESTART:  w = '{OP_NOP,       C_ALWAYS,    S_WAIT};
         default:    w = '{OP_NOP,       C_ALWAYS,    S_WAIT};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tgs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread grid split channels
// Valid/ready channels for the dimension items and the split result items.
// ----------------------------------------------------------------------------
interface tgs_req_if import tgs_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [DIM_W-1:0] dim_m;
   logic [DIM_W-1:0] dim_n;

   modport source (output valid, output dim_m, output dim_n, input ready);
   modport sink   (input valid, input dim_m, input dim_n, output ready);
endinterface

interface tgs_rsp_if import tgs_pkg::*; ;
   logic           valid;
   logic           ready;
   logic [T_W-1:0] split_m;
   logic [T_W-1:0] split_n;

   modport source (output valid, output split_m, output split_n, input ready);
   modport sink   (input valid, input split_m, input split_n, output ready);
endinterface
`default_nettype wire

// ===== rtl/thread_grid_split.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread grid split
// Splits the configured worker count into a row-by-column grid that follows
// the ratio of two problem dimensions, under control of a microcode sequencer.
// ----------------------------------------------------------------------------
// The block takes one item (dim_m, dim_n) at a time and answers one item
// (split_m, split_n). The worker count T is written through csr_wr_en and
// csr_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce. Values above 1024 saturate to 1024 and
// a count of zero answers 0 by 0. The work per item is set by a microcode
// program that steps one control word per cycle. The target row count is
// found by a bit-by-bit search over 11 bits, at most four steps per bit
// through one 12x12 squarer and one 24x32 multiplier. The nearest divisor
// of T is then searched outward from the target with a restoring divider.
// Results go through an output register, so a new item is taken while the
// previous result is still waiting to be read.
// ----------------------------------------------------------------------------
module thread_grid_split import tgs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [T_W-1:0] csr_wr_data,
   tgs_req_if.sink         req_chan,
   tgs_rsp_if.source       rsp_chan
);

   // Configuration register.
   logic [T_W-1:0]    thread_count_ff, thread_count_in;

   // Sequencer.
   step_type          pc_ff, pc_in;
   ucode_word_type    uword;
   logic              branch;

   // Datapath registers.
   logic [T_W-1:0]    t_ff, t_in;
   logic [DIM_W-1:0]  m_ff, m_in;
   logic [DIM_W-1:0]  n_ff, n_in;
   logic [RHS_W-1:0]  rhs_ff, rhs_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [T_W-1:0]    k_ff, k_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [T_W-1:0]    dist_ff, dist_in;
   logic [T_W-1:0]    div_d_ff, div_d_in;
   logic [T_W-1:0]    div_rem_ff, div_rem_in;
   logic [T_W-1:0]    div_quo_ff, div_quo_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [T_W-1:0]    res_m_ff, res_m_in;
   logic [T_W-1:0]    res_n_ff, res_n_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [T_W-1:0]    rsp_m_ff, rsp_m_in;
   logic [T_W-1:0]    rsp_n_ff, rsp_n_in;

   // Combinational helpers.
   logic [T_W-1:0]    cand;
   logic [ODD_W-1:0]  odd;
   logic [T_W:0]      rem_shift;
   logic              rem_ge;
   logic              out_free;

   assign uword    = ucode_rom(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // The candidate sets the current search bit on top of the target so far.
   assign cand      = k_ff | (T_W'(1) << bit_ff);
   assign odd       = {cand, 1'b0} - ODD_W'(1);
   assign rem_shift = {div_rem_ff, div_quo_ff[T_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, div_d_ff};

   assign req_chan.ready   = (pc_ff == S_WAIT);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.split_m = rsp_m_ff;
   assign rsp_chan.split_n = rsp_n_ff;

   // Branch condition selected by the current control word.
   always_comb begin
      case (uword.cond)
         C_NEVER:     branch = 1'b0;
         C_ALWAYS:    branch = 1'b1;
         C_NO_REQ:    branch = !req_chan.valid;
         C_T_ZERO:    branch = (t_ff == '0);
         C_MN_ZERO:   branch = (m_ff == '0) && (n_ff == '0);
         C_CAND_OVER: branch = (cand > t_ff);
         C_BIT_LEFT:  branch = (bit_ff != '0);
         C_K_ZERO:    branch = (k_ff == '0);
         C_K_GE_T:    branch = (k_ff >= t_ff);
         C_DIV_BUSY:  branch = (div_cnt_ff != CNT_W'(1));
         C_REM_ZERO:  branch = (div_rem_ff == '0);
         C_OUT_BUSY:  branch = !out_free;
         default:     branch = 1'b0;
      endcase
      pc_in = branch ? uword.target : step_type'(pc_ff + PC_W'(1));
   end

   // Datapath actions selected by the current control word.
   always_comb begin
      thread_count_in = csr_wr_en ? csr_wr_data : thread_count_ff;
      t_in       = t_ff;
      m_in       = m_ff;
      n_in       = n_ff;
      rhs_in     = rhs_ff;
      sq_in      = sq_ff;
      prod_in    = prod_ff;
      k_in       = k_ff;
      bit_in     = bit_ff;
      dist_in    = dist_ff;
      div_d_in   = div_d_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      res_m_in   = res_m_ff;
      res_n_in   = res_n_ff;
      rsp_m_in   = rsp_m_ff;
      rsp_n_in   = rsp_n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (uword.op)
         OP_NOP: begin
         end
         OP_LATCH: begin
            m_in   = req_chan.dim_m;
            n_in   = req_chan.dim_n;
            t_in   = (thread_count_ff > T_W'(MAX_WORKERS)) ? T_W'(MAX_WORKERS)
                                                            : thread_count_ff;
            k_in   = '0;
            bit_in = BIT_W'(CAND_TOP);
         end
         OP_ZERO: begin
            res_m_in = '0;
            res_n_in = '0;
         end
         OP_RHS: begin
            // Four times T times m, the right side of the exact rounding test.
            rhs_in = {RHS_W'(t_ff) * RHS_W'(m_ff)} << 2;
         end
         OP_SQUARE: begin
            sq_in = SQ_W'(odd) * SQ_W'(odd);
         end
         OP_PROD: begin
            prod_in = PROD_W'(sq_ff) * PROD_W'(n_ff);
         end
         OP_ACCEPT: begin
            if (prod_ff <= PROD_W'(rhs_ff)) begin
               k_in = cand;
            end
         end
         OP_BIT_DEC: begin
            if (bit_ff != '0) begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         OP_SET_FULL: begin
            res_m_in = t_ff;
            res_n_in = T_W'(1);
            dist_in  = '0;
         end
         OP_DIV_DOWN: begin
            div_d_in   = k_ff - dist_ff;
            div_rem_in = '0;
            div_quo_in = t_ff;
            div_cnt_in = CNT_W'(T_W);
         end
         OP_DIV_UP: begin
            div_d_in   = k_ff + dist_ff;
            div_rem_in = '0;
            div_quo_in = t_ff;
            div_cnt_in = CNT_W'(T_W);
         end
         OP_DIV_STEP: begin
            // One restoring step: shift in a dividend bit, subtract if it fits.
            div_rem_in = rem_ge ? T_W'(rem_shift - {1'b0, div_d_ff})
                                : rem_shift[T_W-1:0];
            div_quo_in = {div_quo_ff[T_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff - CNT_W'(1);
         end
         OP_TAKE: begin
            res_m_in = div_d_ff;
            res_n_in = div_quo_ff;
         end
         OP_TAKE_NEXT: begin
            res_m_in = div_d_ff;
            res_n_in = div_quo_ff;
            dist_in  = dist_ff + T_W'(1);
         end
         OP_FALLBACK: begin
            // No usable target: the larger dimension takes up to T workers.
            if (m_ff > n_ff) begin
               res_m_in = (m_ff > DIM_W'(t_ff)) ? t_ff : m_ff[T_W-1:0];
               res_n_in = T_W'(1);
            end else begin
               res_m_in = T_W'(1);
               res_n_in = (n_ff > DIM_W'(t_ff)) ? t_ff : n_ff[T_W-1:0];
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_m_in     = res_m_ff;
               rsp_n_in     = res_n_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         thread_count_ff <= T_W'(1);
         pc_ff           <= S_WAIT;
         rsp_valid_ff    <= 1'b0;
      end else begin
         thread_count_ff <= thread_count_in;
         pc_ff           <= pc_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload and working registers carry no reset.
   always_ff @(posedge clock) begin
      t_ff       <= t_in;
      m_ff       <= m_in;
      n_ff       <= n_in;
      rhs_ff     <= rhs_in;
      sq_ff      <= sq_in;
      prod_ff    <= prod_in;
      k_ff       <= k_in;
      bit_ff     <= bit_in;
      dist_ff    <= dist_in;
      div_d_ff   <= div_d_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_cnt_ff <= div_cnt_in;
      res_m_ff   <= res_m_in;
      res_n_ff   <= res_n_in;
      rsp_m_ff   <= rsp_m_in;
      rsp_n_ff   <= rsp_n_in;
   end

   // The divider is never stepped once its count has run out.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_DIV_A || pc_ff == S_DIV_B) |-> (div_cnt_ff != '0))
      else $error("divider stepped with no steps left");

   // The target search never goes past the worker count.
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_KZERO) |-> (k_ff <= t_ff))
      else $error("target above worker count");

   // An exact trial gives a divisor pair whose product is the worker count.
   a_divisor_exact: assert property (@(posedge clock) disable iff (reset)
      ((pc_ff == S_TEST_A || pc_ff == S_TEST_B) && (div_rem_ff == '0)) |->
      ((2*T_W)'(div_quo_ff) * (2*T_W)'(div_d_ff) == (2*T_W)'(t_ff)))
      else $error("divisor trial does not reproduce worker count");

   // A result item never asks for more workers than the block allows.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_m_ff <= T_W'(MAX_WORKERS) && rsp_n_ff <= T_W'(MAX_WORKERS)))
      else $error("result split above worker limit");

endmodule
`default_nettype wire

// ===== dv/tgs_grid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread grid split checker
// Watches the worker count writes and both channels. It computes the grid for
// every accepted dimension item, queues it, and compares each result item with
// the oldest queued grid, field by field.
// ----------------------------------------------------------------------------
module tgs_grid_checker import tgs_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic [T_W-1:0] csr_wr_data,
   tgs_req_if                  req_mon,
   tgs_rsp_if                  rsp_mon,
   output int                  mismatches,
   output int                  awaited
);

   typedef struct packed {
      logic [T_W-1:0] split_m;
      logic [T_W-1:0] split_n;
   } grid_shape_type;

   logic [T_W-1:0] worker_count;
   grid_shape_type awaited_grids[$];

   // Rows follow round(sqrt(T*m/n)), found as the largest k with
   // (2k-1)^2 * n <= 4*T*m, then moved to the nearest divisor of T.
   function automatic grid_shape_type predict_grid(input logic [T_W-1:0]   count,
                                                   input logic [DIM_W-1:0] m_in,
                                                   input logic [DIM_W-1:0] n_in);
      longint unsigned t, m, n, rhs, k, odd, down, up, rows, cols, c, i;
      grid_shape_type  g;
      t    = (count > MAX_WORKERS) ? MAX_WORKERS : count;
      m    = m_in;
      n    = n_in;
      k    = 0;
      rows = 0;
      cols = 0;
      if (t != 0) begin
         if (m != 0 || n != 0) begin
            rhs = 4 * t * m;
            for (c = 1; c <= t; c++) begin
               odd = 2 * c - 1;
               if (n != 0 && odd * odd > rhs / n) break;
               k = c;
            end
         end
         if (k == 0) begin
            if (m > n) begin
               rows = (m < t) ? m : t;
               cols = 1;
            end else begin
               rows = 1;
               cols = (n < t) ? n : t;
            end
         end else if (k >= t) begin
            rows = t;
            cols = 1;
         end else begin
            // The lower candidate wins a tie in distance.
            for (i = 0; i < k; i++) begin
               down = k - i;
               up   = k + i;
               if (t % down == 0) begin
                  rows = down;
                  cols = t / down;
                  break;
               end
               if (t % up == 0) begin
                  rows = up;
                  cols = t / up;
                  break;
               end
            end
         end
      end
      g.split_m = rows[T_W-1:0];
      g.split_n = cols[T_W-1:0];
      return g;
   endfunction

   always @(posedge clock) begin
      grid_shape_type want;
      if (reset) begin
         awaited_grids.delete();
         worker_count = 1;
      end else begin
         if (csr_wr_en) worker_count = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            awaited_grids.push_back(predict_grid(worker_count, req_mon.dim_m, req_mon.dim_n));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_grids.size() == 0) begin
               $error("unexpected result item: split_m %0d, split_n %0d",
                      rsp_mon.split_m, rsp_mon.split_n);
               mismatches++;
            end else begin
               want = awaited_grids.pop_front();
               if (rsp_mon.split_m !== want.split_m) begin
                  $error("split_m: expected %0d, actual %0d", want.split_m, rsp_mon.split_m);
                  mismatches++;
               end
               if (rsp_mon.split_n !== want.split_n) begin
                  $error("split_n: expected %0d, actual %0d", want.split_n, rsp_mon.split_n);
                  mismatches++;
               end
            end
         end
      end
      awaited = awaited_grids.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread grid split testbench
// Drives dimension items and worker count writes into the block, stalls the
// result channel at random and leaves the result checks to the grid
// checker. The run is a short directed part followed by random phases, one
// per worker count, and ends with a single verdict line.
// ----------------------------------------------------------------------------
module tb_top import tgs_pkg::*; ;

   // Cycles without any handshake or register write before the run is
   // declared hung. The slowest item is one with a prime worker count and the
   // target in the middle, and this limit leaves a wide margin for it.
   localparam int IDLE_LIMIT  = 200000;
   localparam int DRAIN_WAIT  = 300;
   localparam int PHASES      = 14;
   localparam logic [DIM_W-1:0] DIM_MAX = '1;

   // Patterns for the result side: always ready, a coin flip per cycle,
   // mostly ready, or held off for a whole stretch.
   typedef enum logic [1:0] {
      RDY_OPEN,
      RDY_COIN,
      RDY_MOSTLY,
      RDY_HOLD
   } ready_mode_type;

   logic           clock;
   logic           reset;
   logic           csr_wr_en;
   logic [T_W-1:0] csr_wr_data;
   int             mismatches;
   int             awaited;
   int             burst_left;

   tgs_req_if req_chan ();
   tgs_rsp_if rsp_chan ();

   thread_grid_split uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   tgs_grid_checker grid_chk (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .awaited     (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: each stretch of random length picks a stall pattern, so
   // the output register is sometimes drained at once and sometimes left
   // full while the sequencer works on the next item.
   initial begin
      ready_mode_type mode;
      int             stretch;
      mode    = RDY_OPEN;
      stretch = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            mode    = ready_mode_type'($urandom_range(0, 3));
            stretch = $urandom_range(5, 60);
         end
         stretch--;
         case (mode)
            RDY_OPEN:   rsp_chan.ready <= 1'b1;
            RDY_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
            RDY_MOSTLY: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
            default:    rsp_chan.ready <= 1'b0;
         endcase
      end
   end

   // Hang detection: any handshake or register write restarts the count.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_top: errors");
      $finish;
   end

   // Offers one item and holds it until the block takes it. Items go out in
   // bursts; when a burst runs out, valid drops for a gap of random length.
   // Short gaps land inside the target search, long ones span whole items.
   task automatic send_dims(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.dim_m <= m;
      req_chan.dim_n <= n;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
         // A long burst now and then gives stretches with no idling at all.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // The worker count may only change while the block is idle, so the
   // sender first waits until every queued grid has come back.
   task automatic set_workers(input logic [T_W-1:0] count);
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (awaited != 0);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random dimensions. Most items draw each dimension with a random bit
   // width, so the ratio m/n and hence the target row count spread over the
   // whole range instead of piling up at zero or at the worker count.
   task automatic random_dims(output logic [DIM_W-1:0] m, output logic [DIM_W-1:0] n);
      int         bm;
      int         bn;
      logic [DIM_W-1:0] corner[3];
      corner[0] = '0;
      corner[1] = 1;
      corner[2] = DIM_MAX;
      case ($urandom_range(0, 9))
         0: begin
            m = $urandom;
            n = $urandom;
         end
         1: begin
            m = $urandom_range(0, 16);
            n = $urandom_range(0, 16);
         end
         2: begin
            m = corner[$urandom_range(0, 2)];
            n = corner[$urandom_range(0, 2)];
         end
         default: begin
            bm = $urandom_range(0, DIM_W);
            bn = $urandom_range(0, DIM_W);
            m  = $urandom & DIM_W'((64'd1 << bm) - 1);
            n  = $urandom & DIM_W'((64'd1 << bn) - 1);
         end
      endcase
   endtask

   initial begin
      logic [T_W-1:0]   workers;
      logic [DIM_W-1:0] m;
      logic [DIM_W-1:0] n;
      int               items;
      int               effective;

      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_chan.valid <= 1'b0;
      req_chan.dim_m <= '0;
      req_chan.dim_n <= '0;
      burst_left      = 1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed part. The count after reset is one worker, so the item with both
      // dimensions zero must come back as 1 by 0 and the item 5 by 3 as 1 by 1.
      send_dims(0, 0);
      send_dims(5, 3);

      // Twelve workers: both dimensions zero, each one zero alone, the
      // extremes, a target that lands on a divisor, a target of zero, and a
      // target at or above the worker count.
      set_workers(12);
      send_dims(0, 0);
      send_dims(0, 7);
      send_dims(7, 0);
      send_dims(DIM_MAX, 0);
      send_dims(0, DIM_MAX);
      send_dims(DIM_MAX, DIM_MAX);
      send_dims(1, 1);
      send_dims(5, 3);
      send_dims(3, 5);
      send_dims(1, DIM_MAX);
      send_dims(DIM_MAX, 1);
      send_dims(100, 1000);

      // A worker count of zero answers 0 by 0 whatever the dimensions.
      set_workers(0);
      send_dims(1, 1);
      send_dims(DIM_MAX, DIM_MAX);

      // The largest register value saturates to the maximum worker count.
      set_workers('1);
      send_dims(1, 1);
      send_dims(DIM_MAX, 1);
      send_dims(1, DIM_MAX);
      send_dims(3, 7);

      // A prime count forces the divisor search all the way down to one.
      set_workers(1021);
      send_dims(1, 4);
      send_dims(1, 1);

      // Random phases, one worker count each. Large counts make the divisor
      // search long, so those phases get fewer items.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       workers = 0;
            1:       workers = 1;
            2:       workers = 2;
            3:       workers = '1;
            4:       workers = T_W'(MAX_WORKERS);
            5:       workers = 1021;
            6:       workers = 1023;
            11:      workers = T_W'($urandom_range(65, 255));
            12:      workers = T_W'($urandom_range(256, MAX_WORKERS));
            13:      workers = T_W'($urandom_range(0, 2047));
            default: workers = T_W'($urandom_range(3, 64));
         endcase
         effective = (workers > MAX_WORKERS) ? MAX_WORKERS : workers;
         items     = (effective > 256) ? 20 : 80;
         set_workers(workers);
         repeat (items) begin
            random_dims(m, n);
            send_dims(m, n);
         end
      end

      // Let every queued grid come back, then give the block time to show
      // any result item that should not be there.
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (awaited != 0);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (mismatches == 0 && awaited == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tgs_pkg.sv
rtl/tgs_if.sv
rtl/thread_grid_split.sv
dv/tgs_grid_checker.sv
dv/tb_top.sv
